// ===== design/spq_pkg.sv =====
// ============================================================================
// spq_pkg: shared types and constants for the sorted insert priority queue
// Payload structs, controller state encoding and datapath command bundle.
// ============================================================================
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 256;
    localparam logic [7:0] SYM_LOW  = 8'd0;
    localparam logic [7:0] SYM_HIGH = 8'd255;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [8:0]  node_id;
        logic [7:0]  symbol;
        logic [31:0] frequency;
    } spq_in_t;

    typedef struct packed {
        logic        accepted;
        logic [8:0]  out_node_id;
        logic [7:0]  out_symbol;
        logic [31:0] out_frequency;
        logic [8:0]  occupancy;
        logic        is_empty;
        logic        is_full;
    } spq_out_t;

    typedef struct packed {
        logic [8:0]  node_id;
        logic [7:0]  symbol;
        logic [31:0] frequency;
    } spq_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DEQ,
        ST_OUT
    } spq_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item, set slot to tail
        logic rd_issue;   // read left-of-slot (enqueue) or head (dequeue)
        logic shift;      // move left entry into slot, step slot left
        logic place;      // write new entry at slot, advance tail
        logic pop;        // advance head
        logic result_ok;  // capture result as accepted
        logic result_nak; // capture result as refused
    } spq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_deq;
        logic full;
        logic empty;
        logic at_head;    // slot equals head
        logic greater;    // left entry key is greater than new key
    } spq_stat_t;

endpackage

// ===== design/spq_datapath.sv =====
// ============================================================================
// spq_datapath: entry memory, pointers and key compare
// Holds the circular sorted store and does one shift or compare per step.
// ============================================================================
module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  spq_in_t   in_item,
    input  logic      bias_enable,
    input  spq_cmd_t  cmd,
    output spq_stat_t stat,
    output spq_out_t  result
);

    spq_entry_t mem [CAPACITY];

    spq_entry_t       new_reg, new_next;
    logic             is_deq_reg;
    spq_entry_t       rd_data_reg;
    logic [AW-1:0]    slot_reg, head_reg, tail_reg;
    logic [CW-1:0]    count_reg;
    spq_out_t         result_reg;

    logic [AW-1:0] slot_left;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] count_next;
    logic          biased;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
        logic [AW-1:0] r;
        if (i == AW'(CAPACITY - 1))
            r = '0;
        else
            r = i + AW'(1);
        return r;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
        logic [AW-1:0] r;
        if (i == '0)
            r = AW'(CAPACITY - 1);
        else
            r = i - AW'(1);
        return r;
    endfunction

    assign slot_left = wrap_dec(slot_reg);
    assign rd_addr   = is_deq_reg ? head_reg : slot_left;

    assign biased = bias_enable
                    && (in_item.symbol == SYM_LOW || in_item.symbol == SYM_HIGH)
                    && (in_item.frequency != 32'd0);

    always_comb
    begin
        new_next.node_id   = in_item.node_id;
        new_next.symbol    = in_item.symbol;
        new_next.frequency = biased ? in_item.frequency - 32'd1 : in_item.frequency;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            new_reg <= new_next;
        if (cmd.rd_issue)
            rd_data_reg <= mem[rd_addr];
        if (cmd.shift)
            mem[slot_reg] <= rd_data_reg;
        else if (cmd.place)
            mem[slot_reg] <= new_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.place)
            count_next = count_reg + CW'(1);
        else if (cmd.pop)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_deq_reg <= 1'b0;
            slot_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            result_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                is_deq_reg <= in_item.action == ACT_DEQUEUE;
                slot_reg   <= tail_reg;
            end
            if (cmd.shift)
                slot_reg <= slot_left;
            if (cmd.place)
                tail_reg <= wrap_inc(tail_reg);
            if (cmd.pop)
                head_reg <= wrap_inc(head_reg);
            count_reg <= count_next;
            if (cmd.result_ok || cmd.result_nak)
            begin
                result_reg.accepted      <= cmd.result_ok;
                result_reg.out_node_id   <= (cmd.result_ok && is_deq_reg) ?
                                            rd_data_reg.node_id : 9'd0;
                result_reg.out_symbol    <= (cmd.result_ok && is_deq_reg) ?
                                            rd_data_reg.symbol : 8'd0;
                result_reg.out_frequency <= (cmd.result_ok && is_deq_reg) ?
                                            rd_data_reg.frequency : 32'd0;
                result_reg.occupancy     <= 9'(count_next);
                result_reg.is_empty      <= count_next == '0;
                result_reg.is_full       <= count_next == CW'(CAPACITY);
            end
        end
    end

    assign stat.is_deq  = is_deq_reg;
    assign stat.full    = count_reg == CW'(CAPACITY);
    assign stat.empty   = count_reg == '0;
    assign stat.at_head = slot_reg == head_reg;
    assign stat.greater = (rd_data_reg.frequency > new_reg.frequency)
                          || (rd_data_reg.frequency == new_reg.frequency
                              && rd_data_reg.symbol > new_reg.symbol);

    assign result = result_reg;

endmodule

// ===== design/spq_ctrl.sv =====
// ============================================================================
// spq_ctrl: sequencer for enqueue insertion walk and dequeue
// Steps the datapath through read, compare and shift until the slot is found.
// ============================================================================
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_stall,
    input  spq_stat_t stat,
    output logic      in_stall,
    output logic      out_valid,
    output spq_cmd_t  cmd
);

    spq_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (stat.is_deq)
                begin
                    if (stat.empty)
                    begin
                        cmd.result_nak = 1'b1;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = ST_DEQ;
                    end
                end
                else if (stat.full)
                begin
                    cmd.result_nak = 1'b1;
                    state_next     = ST_OUT;
                end
                else if (stat.at_head)
                begin
                    cmd.place     = 1'b1;
                    cmd.result_ok = 1'b1;
                    state_next    = ST_OUT;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (stat.greater)
                begin
                    cmd.shift  = 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    cmd.place     = 1'b1;
                    cmd.result_ok = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_DEQ:
            begin
                cmd.pop       = 1'b1;
                cmd.result_ok = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== design/sorted_insert_priority_queue.sv =====
// ============================================================================
// sorted_insert_priority_queue: bounded min-priority queue in sorted order
// Insertion-sorted circular store; enqueue walks from tail, dequeue pops head.
// ============================================================================
//  channel  | signals                      | beat
//  in       | in_valid, in_stall, in_data  | one enqueue or dequeue request
//  out      | out_valid, out_stall, out_data | one result per request
//  cfg      | cfg_valid, cfg_ready, cfg_data | bias_enable write
//
//  Enqueue walks from the tail and moves each larger entry one place right;
//  each move reads the left entry in ST_READ, then compares and shifts it in
//  ST_CMP. Reset clears pointers, count, state and sets bias_enable; the
//  entry memory is not cleared. Input is stalled from acceptance until the
//  result beat is taken.
module sorted_insert_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  spq_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output spq_out_t out_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    logic      bias_enable_reg;
    logic      in_fire;
    spq_cmd_t  cmd;
    spq_stat_t stat;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bias_enable_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            bias_enable_reg <= cfg_data;
    end

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    spq_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_item     (in_data),
        .bias_enable (bias_enable_reg),
        .cmd         (cmd),
        .stat        (stat),
        .result      (out_data)
    );

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("input open while result pending");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.is_empty && out_data.is_full))
        else $error("empty and full together");

    a_deq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.accepted) |->
            (out_data.out_frequency == 32'd0 && out_data.out_node_id == 9'd0))
        else $error("refused op carries data");

endmodule

// ===== verif/tb_sorted_insert_priority_queue.sv =====
// ============================================================================
// tb_sorted_insert_priority_queue: checks the sorted insert priority queue
// Drives random and directed enqueue/dequeue beats with random gaps and
// stalls, predicts every result with a sorted queue model and compares.
// ============================================================================
module tb_sorted_insert_priority_queue;
    import spq_pkg::*;

    localparam int QCAP = DEFAULT_CAPACITY;

    class pq_scoreboard;
        spq_entry_t sorted_q[$];
        spq_out_t   pending_q[$];
        bit         bias_on;
        int         errors;
        int         checked;
        int         enq_ok;
        int         deq_ok;
        int         refused;

        function new();
            bias_on = 1'b1;
            errors  = 0;
            checked = 0;
            enq_ok  = 0;
            deq_ok  = 0;
            refused = 0;
        endfunction

        function void note_request(spq_in_t req);
            spq_out_t   res;
            spq_entry_t ent;
            int         pos;
            res = '0;
            if (req.action == ACT_ENQUEUE) begin
                if (sorted_q.size() < QCAP) begin
                    ent.node_id   = req.node_id;
                    ent.symbol    = req.symbol;
                    ent.frequency = req.frequency;
                    if (bias_on && (req.symbol == SYM_LOW || req.symbol == SYM_HIGH)
                        && req.frequency != 0)
                        ent.frequency = req.frequency - 32'd1;
                    pos = sorted_q.size();
                    while (pos > 0 && (sorted_q[pos-1].frequency > ent.frequency ||
                           (sorted_q[pos-1].frequency == ent.frequency &&
                            sorted_q[pos-1].symbol > ent.symbol)))
                        pos--;
                    sorted_q.insert(pos, ent);
                    res.accepted = 1'b1;
                    enq_ok++;
                end
                else
                    refused++;
            end
            else begin
                if (sorted_q.size() != 0) begin
                    ent = sorted_q.pop_front();
                    res.accepted      = 1'b1;
                    res.out_node_id   = ent.node_id;
                    res.out_symbol    = ent.symbol;
                    res.out_frequency = ent.frequency;
                    deq_ok++;
                end
                else
                    refused++;
            end
            res.occupancy = 9'(sorted_q.size());
            res.is_empty  = (sorted_q.size() == 0);
            res.is_full   = (sorted_q.size() == QCAP);
            pending_q.push_back(res);
        endfunction

        function void check_result(spq_out_t got);
            spq_out_t exp_r;
            checked++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.accepted !== exp_r.accepted) begin
                errors++;
                $display("%0t: accepted exp %0d got %0d", $time, exp_r.accepted,
                         got.accepted);
            end
            if (got.out_node_id !== exp_r.out_node_id) begin
                errors++;
                $display("%0t: out_node_id exp %0d got %0d", $time,
                         exp_r.out_node_id, got.out_node_id);
            end
            if (got.out_symbol !== exp_r.out_symbol) begin
                errors++;
                $display("%0t: out_symbol exp %0d got %0d", $time,
                         exp_r.out_symbol, got.out_symbol);
            end
            if (got.out_frequency !== exp_r.out_frequency) begin
                errors++;
                $display("%0t: out_frequency exp %0d got %0d", $time,
                         exp_r.out_frequency, got.out_frequency);
            end
            if (got.occupancy !== exp_r.occupancy) begin
                errors++;
                $display("%0t: occupancy exp %0d got %0d", $time,
                         exp_r.occupancy, got.occupancy);
            end
            if (got.is_empty !== exp_r.is_empty) begin
                errors++;
                $display("%0t: is_empty exp %0d got %0d", $time,
                         exp_r.is_empty, got.is_empty);
            end
            if (got.is_full !== exp_r.is_full) begin
                errors++;
                $display("%0t: is_full exp %0d got %0d", $time,
                         exp_r.is_full, got.is_full);
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    spq_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    spq_out_t out_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_data;

    pq_scoreboard sb;
    int  idle_pct;
    int  quiet_cycles;
    int  sent;
    bit  timed_out;

    sorted_insert_priority_queue DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stall, check on accepted beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < idle_pct);
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired at %0t", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    // valid stays up after the accept edge; an idle gap in the next call or a drain drops it
    task automatic send_request(input spq_in_t req);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(req);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_op(input logic act, input int node, input int sym,
                           input logic [31:0] freq);
        spq_in_t req;
        req.action    = act;
        req.node_id   = 9'(node);
        req.symbol    = 8'(sym);
        req.frequency = freq;
        send_request(req);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_bias(input logic val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.bias_on = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_freq();
        case ($urandom_range(3))
            0: return $urandom_range(3);
            1: return $urandom_range(12);
            2: return 32'hFFFF_FFFF - $urandom_range(2);
            default: return $urandom();
        endcase
    endfunction

    function automatic int rand_sym();
        case ($urandom_range(3))
            0: return int'(SYM_LOW);
            1: return int'(SYM_HIGH);
            2: return $urandom_range(3);
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic random_phase(input int count, input int enq_pct);
        repeat (count)
        begin
            if ($urandom_range(99) < enq_pct)
                send_op(ACT_ENQUEUE, $urandom_range(511), rand_sym(), rand_freq());
            else
                send_op(ACT_DEQUEUE, $urandom_range(511), $urandom_range(255),
                        $urandom());
        end
    endtask

    initial
    begin
        sb           = new();
        timed_out    = 1'b0;
        idle_pct     = 17;
        sent         = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        out_stall    = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty dequeue, bias edges, tie ordering, extremes
        send_op(ACT_DEQUEUE, 511, 255, 32'hFFFF_FFFF);
        send_op(ACT_ENQUEUE, 511, 255, 32'hFFFF_FFFF);
        send_op(ACT_ENQUEUE, 0, 0, 0);
        send_op(ACT_ENQUEUE, 1, 255, 0);
        send_op(ACT_ENQUEUE, 2, 0, 1);
        send_op(ACT_ENQUEUE, 3, 7, 5);
        send_op(ACT_ENQUEUE, 4, 7, 5);
        send_op(ACT_ENQUEUE, 5, 3, 5);
        send_op(ACT_ENQUEUE, 6, 128, 32'h8000_0000);
        repeat (9) send_op(ACT_DEQUEUE, 0, 0, 0);

        write_bias(1'b0);
        send_op(ACT_ENQUEUE, 10, 255, 0);
        send_op(ACT_ENQUEUE, 11, 0, 1);
        send_op(ACT_ENQUEUE, 12, 255, 1);
        repeat (3) send_op(ACT_DEQUEUE, 0, 0, 0);

        // fill to capacity, overfill, drain past empty; ascending keys keep it fast
        idle_pct = 0;
        for (int i = 0; i < QCAP; i++)
            send_op(ACT_ENQUEUE, i, 100, i * 3);
        send_op(ACT_ENQUEUE, 300, 1, 0);
        for (int i = 0; i < 4; i++)
            send_op(ACT_DEQUEUE, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            send_op(ACT_ENQUEUE, 400 + i, 50, 32'hFFFF_FFF0 + i);
        send_op(ACT_ENQUEUE, 301, 2, 7);
        repeat (QCAP + 2) send_op(ACT_DEQUEUE, 0, 0, 0);

        idle_pct = 17;
        write_bias(1'b1);
        random_phase(400, 60);
        write_bias(1'b0);
        random_phase(300, 50);
        idle_pct = 0;
        random_phase(200, 55);
        idle_pct = 17;
        write_bias(1'b1);
        random_phase(300, 45);

        drain_results();
        $display("Ran %0d requests: %0d inserts, %0d removals, %0d refused.",
                 sent, sb.enq_ok, sb.deq_ok, sb.refused);
        $display("Covered full/empty refusals, tie order and both bias settings.");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
